FILE: hw/rtl/joystick_cardinal_direction_lock_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joystick direction lock
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_CARDINAL_DIRECTION_LOCK_ASSERT_SVH
`define JOYSTICK_CARDINAL_DIRECTION_LOCK_ASSERT_SVH

// same-cycle implication
`define JCDL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define JCDL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/jcdl_pkg.sv
// ----------------------------------------------------------------------------
// jcdl_pkg
// Shared widths, direction codes and interface types of the direction lock.
// ----------------------------------------------------------------------------
package jcdl_pkg;

  localparam int AXIS_BITS = 16;                 // stick sample width
  localparam int MAG_W     = AXIS_BITS - 1;      // magnitude / quotient width
  localparam int DZ_W      = 15;                 // deadzone register width
  localparam int CFG_W     = 16;                 // gain / release / margin width
  localparam int OUT_W     = 17;                 // velocity word width
  localparam int DIR_W     = 3;
  localparam int IDX_W     = 4;                  // config index width
  localparam int STEP_W    = $clog2(MAG_W);      // divider step counter
  localparam int CMP_W     = (MAG_W > CFG_W) ? MAG_W : CFG_W;
  localparam int SUM_W     = CMP_W + 1;
  localparam int DZC_W     = (MAG_W > DZ_W) ? MAG_W : DZ_W;

  localparam logic [MAG_W-1:0]     MAG_MAX   = {MAG_W{1'b1}};
  localparam logic [AXIS_BITS-1:0] FULL_CODE = {1'b1, {MAG_W{1'b0}}};

  // held direction codes
  localparam logic [DIR_W-1:0] DIR_NONE     = 3'd0;
  localparam logic [DIR_W-1:0] DIR_FORWARD  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BACKWARD = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE     = 4'd0;
  localparam logic [IDX_W-1:0] REG_DIR_DZ     = 4'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE    = 4'd2;
  localparam logic [IDX_W-1:0] REG_MARGIN     = 4'd3;
  localparam logic [IDX_W-1:0] REG_FWD_SCALE  = 4'd4;
  localparam logic [IDX_W-1:0] REG_LAT_SCALE  = 4'd5;
  localparam logic [IDX_W-1:0] REG_YAW_DZ     = 4'd6;
  localparam logic [IDX_W-1:0] REG_YAW_SCALE  = 4'd7;

  typedef struct packed {
    logic                 start;
    logic [AXIS_BITS-1:0] rem;      // dividend excess, below divisor
    logic [AXIS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [MAG_W-1:0] fm;
    logic [MAG_W-1:0] lm;
    logic             f_neg;
    logic             l_neg;
    logic [DIR_W-1:0] held;
    logic [CFG_W-1:0] rel;
    logic [CFG_W-1:0] margin;
  } dir_in_t;

endpackage

FILE: hw/rtl/jcdl_div.sv
// ----------------------------------------------------------------------------
// jcdl_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jcdl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  jcdl_pkg::div_req_t req,
  output jcdl_pkg::div_rsp_t rsp
);

  localparam logic [jcdl_pkg::STEP_W-1:0] LAST_STEP =
    jcdl_pkg::STEP_W'(jcdl_pkg::MAG_W - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [jcdl_pkg::STEP_W-1:0]       cnt_r;
  logic [jcdl_pkg::AXIS_BITS-1:0]    rem_r;
  logic [jcdl_pkg::AXIS_BITS-1:0]    div_r;
  logic [jcdl_pkg::MAG_W-1:0]        quot_r;
  logic [jcdl_pkg::AXIS_BITS:0]      shifted;
  logic                              fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem;
      div_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= jcdl_pkg::AXIS_BITS'(shifted - {1'b0, div_r});
      end else begin
        rem_r <= shifted[jcdl_pkg::AXIS_BITS-1:0];
      end
      quot_r <= {quot_r[jcdl_pkg::MAG_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

FILE: hw/rtl/jcdl_dir.sv
// ----------------------------------------------------------------------------
// jcdl_dir
// Held-direction decision with release and switch-margin hysteresis.
// ----------------------------------------------------------------------------
module jcdl_dir (
  input  jcdl_pkg::dir_in_t           din,
  output logic [jcdl_pkg::DIR_W-1:0]  dir
);

  logic [jcdl_pkg::MAG_W-1:0] mx;
  logic [jcdl_pkg::MAG_W-1:0] held_m;
  logic [jcdl_pkg::MAG_W-1:0] other_m;
  logic [jcdl_pkg::DIR_W-1:0] fdir;
  logic [jcdl_pkg::DIR_W-1:0] ldir;
  logic                       hold_fwd;
  logic                       released;
  logic                       give_way;

  always_comb begin
    mx       = (din.fm > din.lm) ? din.fm : din.lm;
    fdir     = din.f_neg ? jcdl_pkg::DIR_BACKWARD : jcdl_pkg::DIR_FORWARD;
    ldir     = din.l_neg ? jcdl_pkg::DIR_RIGHT : jcdl_pkg::DIR_LEFT;
    hold_fwd = (din.held == jcdl_pkg::DIR_FORWARD) ||
               (din.held == jcdl_pkg::DIR_BACKWARD);
    held_m   = hold_fwd ? din.fm : din.lm;
    other_m  = hold_fwd ? din.lm : din.fm;
    released = jcdl_pkg::CMP_W'(mx) <= jcdl_pkg::CMP_W'(din.rel);
    // other axis takes over when the held one drops out or is beaten by margin
    give_way = (jcdl_pkg::CMP_W'(held_m) <= jcdl_pkg::CMP_W'(din.rel)) ||
               (jcdl_pkg::SUM_W'(other_m) >
                jcdl_pkg::SUM_W'(held_m) + jcdl_pkg::SUM_W'(din.margin));

    if (released) begin
      dir = jcdl_pkg::DIR_NONE;
    end else if (din.held == jcdl_pkg::DIR_NONE) begin
      dir = (din.fm >= din.lm) ? fdir : ldir;   // tie goes to the forward axis
    end else if (give_way) begin
      dir = hold_fwd ? ldir : fdir;
    end else begin
      dir = hold_fwd ? fdir : ldir;
    end
  end

endmodule

FILE: hw/rtl/joystick_cardinal_direction_lock.sv
// ----------------------------------------------------------------------------
// joystick_cardinal_direction_lock
// Joystick deadzone, rescale, gain and single-axis direction lock.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) takes one stick sample word: left x,
//    left y and right x. in_stall is high while a sample is being worked on.
//  - Result channel (out_valid / out_stall) gives forward, lateral and yaw
//    velocity plus the held direction. One result word per sample while
//    enable is set; with enable clear a sample is taken and dropped.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//    ready; write it only while the block is idle.
//  - Each axis is rescaled by one shared restoring divider, one quotient bit
//    per cycle, then one 15x16 multiply. An axis inside its deadzone skips
//    the divider.
//  - Each axis passes the load, divide (skipped in the deadzone), multiply
//    and sign states, then the output state loads the result. The next
//    sample is taken the cycle after the result is loaded.
//  - The result sits in an output register; a new sample may be accepted
//    while it waits. A finished sample waits in the final state until the
//    output register is free.
//  - Reset (rst_n low, synchronous) restores register defaults, clears the
//    held direction to none and drops any word in flight.
// ----------------------------------------------------------------------------
`include "joystick_cardinal_direction_lock_assert.svh"

module joystick_cardinal_direction_lock (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_left_x,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_left_y,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_right_x,
  // command output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jcdl_pkg::OUT_W-1:0]    out_vel_forward,
  output logic signed [jcdl_pkg::OUT_W-1:0]    out_vel_lateral,
  output logic signed [jcdl_pkg::OUT_W-1:0]    out_vel_yaw,
  output logic        [jcdl_pkg::DIR_W-1:0]    out_held_direction,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [jcdl_pkg::IDX_W-1:0]    cfg_index,
  input  logic        [jcdl_pkg::CFG_W-1:0]    cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;   // deadzone check, divider start
  localparam logic [2:0] S_DIV  = 3'd2;   // wait for quotient
  localparam logic [2:0] S_MUL  = 3'd3;   // gain multiply
  localparam logic [2:0] S_SGN  = 3'd4;   // restore sign, next axis
  localparam logic [2:0] S_OUT  = 3'd5;   // direction decision, load result

  // axis order through the shared unit
  localparam logic [1:0] AX_FWD = 2'd0;
  localparam logic [1:0] AX_LAT = 2'd1;
  localparam logic [1:0] AX_YAW = 2'd2;

  localparam int PROD_W = jcdl_pkg::MAG_W + jcdl_pkg::CFG_W;

  // config registers
  logic                        enable_r;
  logic [jcdl_pkg::DZ_W-1:0]   dir_dz_r;
  logic [jcdl_pkg::CFG_W-1:0]  release_r;
  logic [jcdl_pkg::CFG_W-1:0]  margin_r;
  logic [jcdl_pkg::CFG_W-1:0]  fwd_scale_r;
  logic [jcdl_pkg::CFG_W-1:0]  lat_scale_r;
  logic [jcdl_pkg::DZ_W-1:0]   yaw_dz_r;
  logic [jcdl_pkg::CFG_W-1:0]  yaw_scale_r;

  // sequencer and datapath
  logic [2:0]                      state_r, state_nxt;
  logic [1:0]                      axis_r;
  logic [jcdl_pkg::AXIS_BITS-1:0]  ax_r [3];
  logic [jcdl_pkg::MAG_W-1:0]      n_r;
  logic                            neg_cur_r;
  logic [jcdl_pkg::CFG_W-1:0]      p_r;
  logic [jcdl_pkg::MAG_W-1:0]      mag_r [2];
  logic                            sgn_r [2];
  logic [jcdl_pkg::OUT_W-1:0]      vel_r [3];
  logic [jcdl_pkg::DIR_W-1:0]      held_r;

  // output register
  logic                            out_valid_r;
  logic [jcdl_pkg::OUT_W-1:0]      out_fwd_r;
  logic [jcdl_pkg::OUT_W-1:0]      out_lat_r;
  logic [jcdl_pkg::OUT_W-1:0]      out_yaw_r;
  logic [jcdl_pkg::DIR_W-1:0]      out_dir_r;

  // load-state combinational terms
  logic [jcdl_pkg::AXIS_BITS-1:0]  x_cur;
  logic                            x_min;
  logic [jcdl_pkg::MAG_W-1:0]      mag_cur;
  logic                            neg_v;
  logic [jcdl_pkg::DZ_W-1:0]       dz_raw;
  logic [jcdl_pkg::MAG_W-1:0]      dz_eff;
  logic                            in_dz;
  logic [jcdl_pkg::CFG_W-1:0]      gain_cur;
  logic [PROD_W-1:0]               prod;
  logic [jcdl_pkg::OUT_W-1:0]      p_ext;
  logic                            in_acc;
  logic                            out_free;

  jcdl_pkg::div_req_t               div_req;
  jcdl_pkg::div_rsp_t               div_rsp;
  jcdl_pkg::dir_in_t                dir_in;
  logic [jcdl_pkg::DIR_W-1:0]       dir_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      dir_dz_r    <= '0;
      release_r   <= '0;
      margin_r    <= '0;
      fwd_scale_r <= jcdl_pkg::CFG_W'(4096);
      lat_scale_r <= jcdl_pkg::CFG_W'(4096);
      yaw_dz_r    <= '0;
      yaw_scale_r <= jcdl_pkg::CFG_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jcdl_pkg::REG_ENABLE:    enable_r    <= cfg_data[0];
        jcdl_pkg::REG_DIR_DZ:    dir_dz_r    <= cfg_data[jcdl_pkg::DZ_W-1:0];
        jcdl_pkg::REG_RELEASE:   release_r   <= cfg_data;
        jcdl_pkg::REG_MARGIN:    margin_r    <= cfg_data;
        jcdl_pkg::REG_FWD_SCALE: fwd_scale_r <= cfg_data;
        jcdl_pkg::REG_LAT_SCALE: lat_scale_r <= cfg_data;
        jcdl_pkg::REG_YAW_DZ:    yaw_dz_r    <= cfg_data[jcdl_pkg::DZ_W-1:0];
        jcdl_pkg::REG_YAW_SCALE: yaw_scale_r <= cfg_data;
        default: ;                          // unmapped index, ignored
      endcase
    end
  end

  // ------------------------------------------------------- axis front end
  // v = -x with the most negative code saturating; |v| and sign of v
  always_comb begin
    x_cur   = ax_r[axis_r];
    x_min   = (x_cur == jcdl_pkg::FULL_CODE);
    mag_cur = x_min ? jcdl_pkg::MAG_MAX
                    : (x_cur[jcdl_pkg::AXIS_BITS-1]
                       ? jcdl_pkg::MAG_W'(~x_cur + 1'b1)
                       : x_cur[jcdl_pkg::MAG_W-1:0]);
    neg_v   = !x_cur[jcdl_pkg::AXIS_BITS-1] && (x_cur != '0);
    dz_raw  = (axis_r == AX_YAW) ? yaw_dz_r : dir_dz_r;
    // deadzone above full travel saturates, so the divisor stays nonzero
    dz_eff  = (jcdl_pkg::DZC_W'(dz_raw) > jcdl_pkg::DZC_W'(jcdl_pkg::MAG_MAX))
              ? jcdl_pkg::MAG_MAX : jcdl_pkg::MAG_W'(dz_raw);
    in_dz   = (mag_cur <= dz_eff);
  end

  // (|v|-dz) * FULL / (FULL-dz): the divider shifts in MAG_W zero bits
  always_comb begin
    div_req.start   = (state_r == S_LOAD) && !in_dz;
    div_req.rem     = jcdl_pkg::AXIS_BITS'(mag_cur - dz_eff);
    div_req.divisor = jcdl_pkg::FULL_CODE - jcdl_pkg::AXIS_BITS'(dz_eff);
  end

  jcdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    case (axis_r)
      AX_FWD:  gain_cur = fwd_scale_r;
      AX_LAT:  gain_cur = lat_scale_r;
      default: gain_cur = yaw_scale_r;
    endcase
    prod  = PROD_W'(n_r) * PROD_W'(gain_cur);
    p_ext = jcdl_pkg::OUT_W'(p_r);
  end

  // ------------------------------------------------------ direction logic
  always_comb begin
    dir_in.fm     = mag_r[0];
    dir_in.lm     = mag_r[1];
    dir_in.f_neg  = sgn_r[0];
    dir_in.l_neg  = sgn_r[1];
    dir_in.held   = held_r;
    dir_in.rel    = release_r;
    dir_in.margin = margin_r;
  end

  jcdl_dir u_dir (
    .din (dir_in),
    .dir (dir_new)
  );

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && enable_r) state_nxt = S_LOAD;
      S_LOAD: state_nxt = in_dz ? S_MUL : S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SGN;
      S_SGN:  state_nxt = (axis_r == AX_YAW) ? S_OUT : S_LOAD;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AX_FWD;
      held_r  <= jcdl_pkg::DIR_NONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        axis_r <= AX_FWD;
      end else if (state_r == S_SGN && axis_r != AX_YAW) begin
        axis_r <= axis_r + 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        held_r <= dir_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r[AX_FWD] <= in_left_y;
      ax_r[AX_LAT] <= in_left_x;
      ax_r[AX_YAW] <= in_right_x;
    end
    if (state_r == S_LOAD) begin
      neg_cur_r <= neg_v;
      if (in_dz) begin
        n_r <= '0;
      end
    end
    if (state_r == S_DIV && div_rsp.done) begin
      n_r <= div_rsp.quot;
    end
    if (state_r == S_MUL) begin
      p_r <= prod[PROD_W-1:jcdl_pkg::MAG_W];
    end
    if (state_r == S_SGN) begin
      // a zero result counts as positive
      vel_r[axis_r] <= (neg_cur_r && (n_r != '0)) ? -p_ext : p_ext;
      if (axis_r != AX_YAW) begin
        mag_r[axis_r[0]] <= n_r;
        sgn_r[axis_r[0]] <= neg_cur_r && (n_r != '0);
      end
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_fwd_r <= (dir_new == jcdl_pkg::DIR_FORWARD ||
                    dir_new == jcdl_pkg::DIR_BACKWARD) ? vel_r[AX_FWD] : '0;
      out_lat_r <= (dir_new == jcdl_pkg::DIR_LEFT ||
                    dir_new == jcdl_pkg::DIR_RIGHT) ? vel_r[AX_LAT] : '0;
      out_yaw_r <= vel_r[AX_YAW];
      out_dir_r <= dir_new;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_vel_forward    = out_fwd_r;
  assign out_vel_lateral    = out_lat_r;
  assign out_vel_yaw        = out_yaw_r;
  assign out_held_direction = out_dir_r;

  // ------------------------------------------------------------ assertions
  `JCDL_ASSERT_IMP(a_fwd_only_when_held,
    out_valid_r && out_dir_r != jcdl_pkg::DIR_FORWARD && out_dir_r != jcdl_pkg::DIR_BACKWARD,
    out_fwd_r == '0)
  `JCDL_ASSERT_IMP(a_lat_only_when_held,
    out_valid_r && out_dir_r != jcdl_pkg::DIR_LEFT && out_dir_r != jcdl_pkg::DIR_RIGHT,
    out_lat_r == '0)
  `JCDL_ASSERT_IMP(a_held_moves_with_result,
    held_r != $past(held_r),
    out_valid_r && out_dir_r == held_r)
  `JCDL_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_r == S_DIV)
  `JCDL_ASSERT_NXT(a_enabled_accept_starts, in_acc && enable_r, state_r == S_LOAD)

endmodule

FILE: tb/jcdl_cmd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jcdl_cmd_checker
// Watches the sample, command and register channels of the direction lock,
// predicts each command word from its own register copy and held direction,
// and compares every delivered command against the oldest prediction.
// ----------------------------------------------------------------------------
module jcdl_cmd_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_left_x,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_left_y,
  input  logic signed [jcdl_pkg::AXIS_BITS-1:0] in_right_x,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [jcdl_pkg::OUT_W-1:0]     out_vel_forward,
  input  logic signed [jcdl_pkg::OUT_W-1:0]     out_vel_lateral,
  input  logic signed [jcdl_pkg::OUT_W-1:0]     out_vel_yaw,
  input  logic        [jcdl_pkg::DIR_W-1:0]     out_held_direction,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic        [jcdl_pkg::IDX_W-1:0]     cfg_index,
  input  logic        [jcdl_pkg::CFG_W-1:0]     cfg_data,
  output int                                    fail_count,
  output int                                    outstanding
);
  import jcdl_pkg::*;

  localparam longint FULL = longint'(1) << (AXIS_BITS - 1);

  typedef struct packed {
    logic [OUT_W-1:0] vel_forward;
    logic [OUT_W-1:0] vel_lateral;
    logic [OUT_W-1:0] vel_yaw;
    logic [DIR_W-1:0] held_direction;
  } drive_cmd_t;

  // register copy and held direction
  logic             enable_r;
  logic [DZ_W-1:0]  dir_dz_r;
  logic [CFG_W-1:0] release_r;
  logic [CFG_W-1:0] margin_r;
  logic [CFG_W-1:0] fwd_gain_r;
  logic [CFG_W-1:0] lat_gain_r;
  logic [DZ_W-1:0]  yaw_dz_r;
  logic [CFG_W-1:0] yaw_gain_r;
  logic [DIR_W-1:0] held_dir;

  drive_cmd_t pending_cmds[$];
  int         mismatches = 0;

  // stick reads are inverted; the most negative code saturates
  function automatic longint invert_axis(logic signed [AXIS_BITS-1:0] raw);
    longint v;
    v = raw;
    if (v == -FULL) return FULL - 1;
    return -v;
  endfunction

  function automatic longint deadband_rescale(longint v, longint dz_reg);
    longint dz, mag, n;
    dz  = (dz_reg > FULL - 1) ? FULL - 1 : dz_reg;
    mag = (v < 0) ? -v : v;
    if (mag <= dz) return 0;
    n = ((mag - dz) * FULL) / (FULL - dz);
    if (n > FULL) n = FULL;
    return (v < 0) ? -n : n;
  endfunction

  // gain on the magnitude, so it truncates toward zero
  function automatic logic [OUT_W-1:0] apply_gain(longint v, longint gain);
    longint mag, p;
    mag = (v < 0) ? -v : v;
    p   = (mag * gain) >>> (AXIS_BITS - 1);
    if (v < 0) p = -p;
    return p[OUT_W-1:0];
  endfunction

  function automatic logic [DIR_W-1:0] next_direction(longint fwd, longint lat);
    longint           fm, lm, mx, rel, cur_mag, other_mag;
    logic [DIR_W-1:0] fdir, ldir;
    logic             hold_fwd;
    fm   = (fwd < 0) ? -fwd : fwd;
    lm   = (lat < 0) ? -lat : lat;
    mx   = (fm > lm) ? fm : lm;
    rel  = longint'(release_r);
    fdir = (fwd >= 0) ? DIR_FORWARD : DIR_BACKWARD;
    ldir = (lat >= 0) ? DIR_LEFT : DIR_RIGHT;
    if (mx <= rel) return DIR_NONE;
    if (held_dir == DIR_NONE) return (fm >= lm) ? fdir : ldir;
    hold_fwd  = (held_dir == DIR_FORWARD) || (held_dir == DIR_BACKWARD);
    cur_mag   = hold_fwd ? fm : lm;
    other_mag = hold_fwd ? lm : fm;
    if (cur_mag <= rel || other_mag > cur_mag + longint'(margin_r))
      return hold_fwd ? ldir : fdir;
    return hold_fwd ? fdir : ldir;
  endfunction

  function automatic drive_cmd_t predict_command(logic signed [AXIS_BITS-1:0] lx,
                                                 logic signed [AXIS_BITS-1:0] ly,
                                                 logic signed [AXIS_BITS-1:0] rx);
    longint           fwd, lat, yaw;
    logic [DIR_W-1:0] dir;
    drive_cmd_t       c;
    fwd = deadband_rescale(invert_axis(ly), longint'(dir_dz_r));
    lat = deadband_rescale(invert_axis(lx), longint'(dir_dz_r));
    yaw = deadband_rescale(invert_axis(rx), longint'(yaw_dz_r));
    dir = next_direction(fwd, lat);
    held_dir = dir;
    c.vel_forward    = (dir == DIR_FORWARD || dir == DIR_BACKWARD) ?
                       apply_gain(fwd, longint'(fwd_gain_r)) : '0;
    c.vel_lateral    = (dir == DIR_LEFT || dir == DIR_RIGHT) ?
                       apply_gain(lat, longint'(lat_gain_r)) : '0;
    c.vel_yaw        = apply_gain(yaw, longint'(yaw_gain_r));
    c.held_direction = dir;
    return c;
  endfunction

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      enable_r   = 1'b0;
      dir_dz_r   = '0;
      release_r  = '0;
      margin_r   = '0;
      fwd_gain_r = CFG_W'(4096);
      lat_gain_r = CFG_W'(4096);
      yaw_dz_r   = '0;
      yaw_gain_r = CFG_W'(4096);
      held_dir   = DIR_NONE;
      pending_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:    enable_r   = cfg_data[0];
          REG_DIR_DZ:    dir_dz_r   = cfg_data[DZ_W-1:0];
          REG_RELEASE:   release_r  = cfg_data;
          REG_MARGIN:    margin_r   = cfg_data;
          REG_FWD_SCALE: fwd_gain_r = cfg_data;
          REG_LAT_SCALE: lat_gain_r = cfg_data;
          REG_YAW_DZ:    yaw_dz_r   = cfg_data[DZ_W-1:0];
          REG_YAW_SCALE: yaw_gain_r = cfg_data;
          default: ;
        endcase
      end
      // result before sample: a word accepted now cannot be out yet
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: command word with none expected, actual fwd %0d lat %0d yaw %0d dir %0d",
                   $time, out_vel_forward, out_vel_lateral, out_vel_yaw, out_held_direction);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          if (out_vel_forward !== want.vel_forward) begin
            $display("%0t: vel_forward expected %0d actual %0d", $time,
                     $signed(want.vel_forward), out_vel_forward);
            mismatches++;
          end
          if (out_vel_lateral !== want.vel_lateral) begin
            $display("%0t: vel_lateral expected %0d actual %0d", $time,
                     $signed(want.vel_lateral), out_vel_lateral);
            mismatches++;
          end
          if (out_vel_yaw !== want.vel_yaw) begin
            $display("%0t: vel_yaw expected %0d actual %0d", $time,
                     $signed(want.vel_yaw), out_vel_yaw);
            mismatches++;
          end
          if (out_held_direction !== want.held_direction) begin
            $display("%0t: held_direction expected %0d actual %0d", $time,
                     want.held_direction, out_held_direction);
            mismatches++;
          end
        end
      end
      // disabled: sample dropped, held direction untouched
      if (in_valid && !in_stall && enable_r)
        pending_cmds.push_back(predict_command(in_left_x, in_left_y, in_right_x));
    end
    fail_count  <= mismatches;
    outstanding <= pending_cmds.size();
  end

endmodule

FILE: tb/tb_joystick_cardinal_direction_lock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_cardinal_direction_lock
// Drives stick samples and register writes into the direction lock: a
// directed pass over the axis extremes, deadzones, release and switch
// hysteresis, then random strokes under changing register settings and
// three idle/stall mixes. A side checker predicts and compares each word.
// ----------------------------------------------------------------------------
module tb_joystick_cardinal_direction_lock;
  import jcdl_pkg::*;

  localparam int     SETTLE_CYCLES = 80;    // covers the longest sample latency
  localparam int     QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int     RANDOM_ITEMS  = 1750;
  localparam int     NUM_REGS      = 8;
  localparam longint AXIS_MAX      = (longint'(1) << (AXIS_BITS - 1)) - 1;
  localparam longint AXIS_MIN      = -AXIS_MAX - 1;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [AXIS_BITS-1:0] in_left_x;
  logic signed [AXIS_BITS-1:0] in_left_y;
  logic signed [AXIS_BITS-1:0] in_right_x;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [OUT_W-1:0]     out_vel_forward;
  logic signed [OUT_W-1:0]     out_vel_lateral;
  logic signed [OUT_W-1:0]     out_vel_yaw;
  logic        [DIR_W-1:0]     out_held_direction;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic        [IDX_W-1:0]     cfg_index;
  logic        [CFG_W-1:0]     cfg_data;

  int fail_count;
  int outstanding;

  // idle percentages, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  // deadzones currently programmed, used to aim samples at the edges
  logic [DZ_W-1:0] cur_dir_dz;
  logic [DZ_W-1:0] cur_yaw_dz;

  joystick_cardinal_direction_lock u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_x          (in_left_x),
    .in_left_y          (in_left_y),
    .in_right_x         (in_right_x),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vel_forward    (out_vel_forward),
    .out_vel_lateral    (out_vel_lateral),
    .out_vel_yaw        (out_vel_yaw),
    .out_held_direction (out_held_direction),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  jcdl_cmd_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_x          (in_left_x),
    .in_left_y          (in_left_y),
    .in_right_x         (in_right_x),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vel_forward    (out_vel_forward),
    .out_vel_lateral    (out_vel_lateral),
    .out_vel_yaw        (out_vel_yaw),
    .out_held_direction (out_held_direction),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls at random, one draw per cycle, changed at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // one register write; the channel is dropped right after the handshake
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one sample word; in_valid stays high afterwards so words can go back to back
  task automatic send_sample(input logic signed [AXIS_BITS-1:0] lx,
                             input logic signed [AXIS_BITS-1:0] ly,
                             input logic signed [AXIS_BITS-1:0] rx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_left_x  = lx;
    in_left_y  = ly;
    in_right_x = rx;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, wait for every expected word, then let a dropped
  // (disabled) sample still in flight finish
  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [AXIS_BITS-1:0] clamp_axis(input longint v);
    if (v > AXIS_MAX) return AXIS_MAX[AXIS_BITS-1:0];
    if (v < AXIS_MIN) return AXIS_MIN[AXIS_BITS-1:0];
    return v[AXIS_BITS-1:0];
  endfunction

  // mostly uniform, with weight on the rails, center and deadzone edge
  function automatic logic signed [AXIS_BITS-1:0] random_axis(input logic [DZ_W-1:0] dz);
    longint               v;
    logic [AXIS_BITS-1:0] r;
    case ($urandom_range(0, 11))
      0: v = AXIS_MIN;
      1: v = AXIS_MAX;
      2: v = 0;
      3: begin
        v = longint'(dz) + $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      4: v = longint'($urandom_range(0, 6)) - 3;
      default: begin
        r = $urandom;
        v = $signed(r);
      end
    endcase
    return clamp_axis(v);
  endfunction

  // zero, the top, anything, or a typical low value
  function automatic logic [CFG_W-1:0] pick_level(input int hi, input int typical);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(hi);
      2, 3:    return CFG_W'($urandom_range(0, hi));
      default: return CFG_W'($urandom_range(0, typical));
    endcase
  endfunction

  // every register, with junk in the bits the block drops
  task automatic apply_random_settings();
    logic [CFG_W-1:0] d;
    d    = CFG_W'($urandom);
    d[0] = ($urandom_range(0, 99) < 88);
    cfg_write(REG_ENABLE, d);
    d          = pick_level(32767, 6000);
    cur_dir_dz = d[DZ_W-1:0];
    d[CFG_W-1] = $urandom_range(0, 1);
    cfg_write(REG_DIR_DZ, d);
    cfg_write(REG_RELEASE, pick_level(65535, 8000));
    cfg_write(REG_MARGIN, pick_level(65535, 12000));
    cfg_write(REG_FWD_SCALE, pick_level(65535, 8192));
    cfg_write(REG_LAT_SCALE, pick_level(65535, 8192));
    d          = pick_level(32767, 6000);
    cur_yaw_dz = d[DZ_W-1:0];
    d[CFG_W-1] = $urandom_range(0, 1);
    cfg_write(REG_YAW_DZ, d);
    cfg_write(REG_YAW_SCALE, pick_level(65535, 8192));
    // an index past the map must change nothing
    if ($urandom_range(0, 3) == 0)
      cfg_write(IDX_W'($urandom_range(NUM_REGS, 2 ** IDX_W - 1)), CFG_W'($urandom));
  endtask

  initial begin : stimulus
    int                          phase;
    int                          phase_items;
    int                          chunk_left;
    int                          steps;
    logic signed [AXIS_BITS-1:0] lx;
    logic signed [AXIS_BITS-1:0] ly;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_left_x     = '0;
    in_left_y     = '0;
    in_right_x    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ENABLE;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_dir_dz    = '0;
    cur_yaw_dz    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed ----
    // disabled out of reset: samples are taken and dropped
    send_sample(-16'sd20000, -16'sd20000, 16'sd1234);
    send_sample(16'sd32767, -16'sd32768, -16'sd32768);
    wait_idle(SETTLE_CYCLES);

    // enable only, rest at reset values (no deadzone, gains of 4096/32768)
    cfg_write(REG_ENABLE, 16'h0001);
    send_sample(16'sd0, 16'sd0, 16'sd0);                 // nothing held
    send_sample(16'sd0, -16'sd32768, -16'sd32768);       // forward, negation saturates
    send_sample(16'sd0, 16'sd32767, 16'sd32767);         // backward, full reverse
    send_sample(-16'sd32768, 16'sd0, -16'sd1);           // held axis at zero: over to left
    send_sample(16'sd32767, 16'sd0, 16'sd1);             // right
    send_sample(16'sd0, 16'sd0, 16'sd0);                 // release
    send_sample(16'sd100, 16'sd100, 16'sd0);             // tie from none goes to the fwd axis
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);  // held fwd axis follows its sign
    wait_idle(SETTLE_CYCLES);

    // deadzones at the top swallow the whole stick, gains at the top
    cfg_write(REG_DIR_DZ, 16'hFFFF);
    cfg_write(REG_YAW_DZ, 16'h7FFF);
    cfg_write(REG_FWD_SCALE, 16'hFFFF);
    cfg_write(REG_LAT_SCALE, 16'hFFFF);
    cfg_write(REG_YAW_SCALE, 16'hFFFF);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    wait_idle(SETTLE_CYCLES);
    cfg_write(REG_DIR_DZ, 16'h7FFE);
    cfg_write(REG_YAW_DZ, 16'h7FFE);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32767);   // one code past the deadzone
    wait_idle(SETTLE_CYCLES);

    // hysteresis: release and switch margin, zero forward and yaw gain
    cfg_write(REG_DIR_DZ, 16'd2000);
    cfg_write(REG_RELEASE, 16'd3000);
    cfg_write(REG_MARGIN, 16'd5000);
    cfg_write(REG_FWD_SCALE, 16'd0);
    cfg_write(REG_YAW_DZ, 16'd0);
    cfg_write(REG_YAW_SCALE, 16'd0);
    send_sample(16'sd0, -16'sd20000, 16'sd0);            // forward held
    send_sample(-16'sd15000, -16'sd20000, 16'sd5);       // other axis within margin: stays
    send_sample(-16'sd32767, -16'sd20000, 16'sd0);       // beyond margin: switch to left
    send_sample(-16'sd32767, -16'sd1000, 16'sd0);        // left kept
    send_sample(-16'sd1500, -16'sd1500, 16'sd0);         // inside deadzone: released
    send_sample(16'sd0, -16'sd3000, 16'sd0);             // rescaled below release: none
    send_sample(16'sd0, -16'sd32768, 16'sd0);            // forward
    send_sample(-16'sd32767, -16'sd2100, 16'sd0);        // held axis at release: switch
    wait_idle(SETTLE_CYCLES);

    // release and margin at the top; stray indexes must not alias
    cfg_write(REG_RELEASE, 16'hFFFF);
    cfg_write(REG_MARGIN, 16'hFFFF);
    cfg_write(IDX_W'(NUM_REGS), 16'h0000);
    cfg_write(IDX_W'(2 ** IDX_W - 1), 16'h0000);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768, 16'sd32767);
    wait_idle(SETTLE_CYCLES);

    // enable clear with the dropped bits set
    cfg_write(REG_ENABLE, 16'hFFFE);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0);
    wait_idle(SETTLE_CYCLES);

    // ---- random ----
    // phase 0: sender idles little, receiver a lot; phase 1 the reverse;
    // phase 2 no idling on either side
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      chunk_left  = 0;
      while (phase_items < RANDOM_ITEMS / 3 + 1) begin
        // new register setting every chunk, only with the block idle
        if (chunk_left <= 0) begin
          wait_idle(SETTLE_CYCLES);
          apply_random_settings();
          chunk_left = $urandom_range(60, 160);
        end
        // now and then hold off until the block has drained
        if ($urandom_range(0, 149) == 0) wait_idle(0);
        if ($urandom_range(0, 9) < 7) begin
          // a stroke: the stick drifts, so the held direction is
          // pushed across release and margin thresholds
          steps = $urandom_range(3, 10);
          lx    = random_axis(cur_dir_dz);
          ly    = random_axis(cur_dir_dz);
          repeat (steps) begin
            send_sample(lx, ly, random_axis(cur_yaw_dz));
            lx = clamp_axis(longint'(lx) + longint'($urandom_range(0, 8192)) - 4096);
            ly = clamp_axis(longint'(ly) + longint'($urandom_range(0, 8192)) - 4096);
          end
        end else begin
          steps = 1;
          send_sample(random_axis(cur_dir_dz), random_axis(cur_dir_dz),
                      random_axis(cur_yaw_dz));
        end
        phase_items += steps;
        chunk_left  -= steps;
      end
    end

    wait_idle(SETTLE_CYCLES);
    if (fail_count == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
